/* sv/bra_pkg.sv */
// Shared types, codes and helpers for the bitmap run allocator.
// Used by bra_ctrl, bra_datapath and bitmap_run_allocator; depends on nothing else.
package bra_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int MAP_CFG_W  = 13;
    localparam int BASE_W     = 24;
    localparam int RUN_W      = 12;
    localparam int BIDX_W     = 12;
    localparam int INDEX_W    = 25;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_BYTES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 4'd1;

    localparam logic [MAP_CFG_W-1:0] MAP_BYTES_RESET = 13'd4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef struct packed {
        logic              cmd;
        logic [RUN_W-1:0]  run_length;
        logic [BIDX_W-1:0] byte_index;
        logic [7:0]        byte_value;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic               status;
    } out_t;

    typedef struct packed {
        logic take_item;
        logic clear_step;
        logic do_load;
        logic set_fail;
        logic scan_start;
        logic scan_step;
        logic scan_capture;
        logic mark_start;
        logic mark_step;
        logic set_ok;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic item_is_load;
        logic req_bad;
        logic byte_free;
        logic scan_last;
        logic fits;
        logic mark_last;
    } ctrl_stat_t;

    function automatic logic [2:0] lowest_zero(input logic [7:0] value);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!value[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/bra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/bra_ctrl.sv */
// Controller state machine for the bitmap run allocator.
// Depends on bra_pkg; drives bra_datapath through command/status structs.
module bra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bra_pkg::ctrl_stat_t stat,
    output bra_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECODE  = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_FIT     = 3'd4;
    localparam logic [2:0] S_MARK    = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.item_is_load)
                begin
                    cmd.do_load = 1'b1;
                    state_next  = S_FINISH;
                end
                else if (stat.req_bad)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (stat.byte_free)
                begin
                    cmd.scan_capture = 1'b1;
                    state_next       = S_FIT;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FIT:
            begin
                if (stat.fits)
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = S_MARK;
                end
                else
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/bra_datapath.sv */
// Datapath of the bitmap run allocator: config registers, scan and mark
// counters, map RAM port muxing and the result/output registers. Uses bra_pkg.
module bra_datapath #(
    parameter int MAP_BYTES = 4096,
    parameter int MAX_RUN   = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bra_pkg::in_t                      in_data,
    output bra_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    input  logic [bra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bra_pkg::ctrl_cmd_t                cmd,
    output bra_pkg::ctrl_stat_t               stat,
    output logic                              ram_we,
    output logic [(MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1)-1:0] ram_waddr,
    output logic [7:0]                        ram_wdata,
    output logic [(MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1)-1:0] ram_raddr,
    input  logic [7:0]                        ram_rdata
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int NW = $clog2(MAP_BYTES + 1);
    localparam int BW = AW + 3;
    localparam int CW = NW + 3;
    localparam int KW = (CW > bra_pkg::RUN_W) ? CW : bra_pkg::RUN_W;
    localparam int PW = 17;

    logic [bra_pkg::MAP_CFG_W-1:0] map_cfg_reg;
    logic [bra_pkg::BASE_W-1:0]    base_reg;
    logic [AW-1:0]                 clr_cnt_reg;
    logic [AW-1:0]                 clr_cnt_next;
    bra_pkg::in_t                  item_reg;
    bra_pkg::in_t                  item_next;
    logic [AW-1:0]                 scan_addr_reg;
    logic [AW-1:0]                 scan_addr_next;
    logic [BW-1:0]                 first_reg;
    logic [BW-1:0]                 first_next;
    logic [BW-1:0]                 last_reg;
    logic [BW-1:0]                 last_next;
    logic [AW-1:0]                 mark_addr_reg;
    logic [AW-1:0]                 mark_addr_next;
    bra_pkg::out_t                 res_reg;
    bra_pkg::out_t                 res_next;
    bra_pkg::out_t                 out_reg;
    bra_pkg::out_t                 out_next;

    logic [NW-1:0] bytes;
    logic [CW-1:0] total;
    logic [KW-1:0] room;
    logic [KW-1:0] run_ext;
    logic          load_in_range;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;

    assign out_data = out_reg;

    always_comb
    begin
        if (PW'(map_cfg_reg) > PW'(MAP_BYTES))
        begin
            bytes = NW'(MAP_BYTES);
        end
        else
        begin
            bytes = NW'(map_cfg_reg);
        end
        total         = {bytes, 3'b000};
        run_ext       = KW'(item_reg.run_length);
        room          = KW'(total) - KW'(first_reg);
        load_in_range = PW'(item_reg.byte_index) < PW'(MAP_BYTES);
        lo            = (mark_addr_reg == first_reg[BW-1:3]) ? first_reg[2:0] : 3'd0;
        hi            = (mark_addr_reg == last_reg[BW-1:3]) ? last_reg[2:0] : 3'd7;
        mask          = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    end

    always_comb
    begin
        stat.clear_last   = (clr_cnt_reg == AW'(MAP_BYTES - 1));
        stat.item_is_load = (item_reg.cmd == bra_pkg::CMD_LOAD);
        stat.req_bad      = (item_reg.run_length == '0)
                         || (PW'(item_reg.run_length) > PW'(MAX_RUN))
                         || (bytes == '0);
        stat.byte_free    = (ram_rdata != bra_pkg::FULL_BYTE);
        stat.scan_last    = (NW'(scan_addr_reg) == bytes - NW'(1));
        stat.fits         = (run_ext <= room);
        stat.mark_last    = (mark_addr_reg == last_reg[BW-1:3]);
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        scan_addr_next = scan_addr_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        mark_addr_next = mark_addr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = mark_addr_reg;
        ram_wdata      = ram_rdata | mask;
        ram_raddr      = scan_addr_reg;

        if (cmd.clear_step)
        begin
            ram_we       = 1'b1;
            ram_waddr    = clr_cnt_reg;
            ram_wdata    = '0;
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if (cmd.take_item)
        begin
            item_next = in_data;
        end
        if (cmd.do_load)
        begin
            ram_we               = load_in_range;
            ram_waddr            = AW'(item_reg.byte_index);
            ram_wdata            = item_reg.byte_value;
            res_next.first_index = '0;
            res_next.status      = bra_pkg::ST_DONE;
        end
        if (cmd.set_fail)
        begin
            res_next.first_index = '0;
            res_next.status      = bra_pkg::ST_FULL;
        end
        if (cmd.scan_start)
        begin
            ram_raddr      = '0;
            scan_addr_next = '0;
        end
        if (cmd.scan_step)
        begin
            ram_raddr      = scan_addr_reg + AW'(1);
            scan_addr_next = scan_addr_reg + AW'(1);
        end
        if (cmd.scan_capture)
        begin
            first_next = {scan_addr_reg, bra_pkg::lowest_zero(ram_rdata)};
        end
        if (cmd.mark_start)
        begin
            ram_raddr      = first_reg[BW-1:3];
            mark_addr_next = first_reg[BW-1:3];
            last_next      = BW'(KW'(first_reg) + run_ext - KW'(1));
        end
        if (cmd.mark_step)
        begin
            ram_we         = 1'b1;
            ram_raddr      = mark_addr_reg + AW'(1);
            mark_addr_next = mark_addr_reg + AW'(1);
        end
        if (cmd.set_ok)
        begin
            res_next.first_index = bra_pkg::INDEX_W'(first_reg)
                                 + bra_pkg::INDEX_W'(base_reg);
            res_next.status      = bra_pkg::ST_DONE;
        end
        if (cmd.out_load)
        begin
            out_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cfg_reg <= bra_pkg::MAP_BYTES_RESET;
            base_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_valid && cfg_index == bra_pkg::REG_MAP_BYTES)
            begin
                map_cfg_reg <= cfg_data[bra_pkg::MAP_CFG_W-1:0];
            end
            if (cfg_valid && cfg_index == bra_pkg::REG_BASE_OFFSET)
            begin
                base_reg <= cfg_data[bra_pkg::BASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        scan_addr_reg <= scan_addr_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        mark_addr_reg <= mark_addr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

/* sv/bitmap_run_allocator.sv */
// Bitmap run allocator top level: allocates a run from the first free bit of a byte map.
// A load passes through decode and finish before its result is valid; an allocation also scans
// map bytes for a free bit and marks the run's bytes, one map RAM access each per cycle.
// One item at a time, taken only once the previous one is done; the next is taken while a result waits.
// After reset a clearing pass zeroes the map, one byte per cycle, with no item taken;
// configuration writes are taken at any time.
module bitmap_run_allocator #(
    parameter int MAP_BYTES = 4096,
    parameter int MAX_RUN   = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bra_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bra_pkg::out_t                  out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    bra_pkg::ctrl_cmd_t  cmd;
    bra_pkg::ctrl_stat_t stat;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bra_datapath #(
        .MAP_BYTES (MAP_BYTES),
        .MAX_RUN   (MAX_RUN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
